>>> src/assert_macros.svh
// Assertion macros for radial_distortion_map.sv; they use the local clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked only while out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> src/rdm_pkg.sv
// Types and constants of the radial distortion map.
package rdm_pkg;

    localparam int IMG_WIDTH  = 720;
    localparam int IMG_HEIGHT = 540;
    localparam int CX = IMG_WIDTH / 2;
    localparam int CY = IMG_HEIGHT / 2;

    localparam int PIX_W   = 10;
    localparam int OUT_W   = 15;
    localparam int K_W     = 24;
    localparam int FOC_W   = 20;
    localparam int INV_W   = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam int CMAX   = (CX > CY) ? CX : CY;
    localparam int CEN_W  = $clog2(CMAX + 1);
    localparam int DIFF_W = ((CEN_W > PIX_W) ? CEN_W : PIX_W) + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_K1     = 3'd0,
        REG_K2     = 3'd1,
        REG_K3     = 3'd2,
        REG_FX     = 3'd3,
        REG_FY     = 3'd4,
        REG_INV_FX = 3'd5,
        REG_INV_FY = 3'd6
    } cfg_reg_t;

    localparam logic [FOC_W-1:0] FOCAL_RST = FOC_W'(131072);
    localparam logic [INV_W-1:0] INV_RST   = INV_W'(32768);

endpackage

>>> src/rdm_if.sv
// Channel interfaces: pixel coordinates in, distorted positions out, register writes.
interface rdm_pix_if;
    import rdm_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
    modport source (output valid, pixel_col, pixel_row, input ready);
    modport sink   (input valid, pixel_col, pixel_row, output ready);
endinterface

interface rdm_map_if;
    import rdm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] map_x;
    logic signed [OUT_W-1:0] map_y;
    modport source (output valid, map_x, map_y, input ready);
    modport sink   (input valid, map_x, map_y, output ready);
endinterface

interface rdm_cfg_if;
    import rdm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/radial_distortion_map.sv
// Top level: pipelined Brown-Conrady radial distortion coordinate map.
//
//  channel | dir | payload                      | handshake
//  pix     | in  | pixel_col, pixel_row         | valid/ready
//  map     | out | map_x, map_y (signed Q.4)    | valid/ready
//  cfg     | in  | index, data (register write) | valid/ready, always ready
//
// Ten register stages; one item per clock while the output takes results.
// Each stage holds one step (multiplies, adds or clamps) of the chain x, r2, r4, r6, s, xd, pixel.
// Stages advance independently: a stage moves when empty or when the next moves,
// so bubbles close up while the output waits. Reset clears all valid bits and
// loads the default registers; no clearing pass.
`include "assert_macros.svh"

module radial_distortion_map
    import rdm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    rdm_pix_if.sink  pix,
    rdm_map_if.source map,
    rdm_cfg_if.sink  cfg
);

    localparam int NSTG   = 10;
    localparam int P_W    = DIFF_W + INV_W + 1;
    localparam int XN_W   = 30;
    localparam int SQ_W   = 57;
    localparam int SUM_W  = SQ_W + 1;
    localparam int R2_W   = 29;
    localparam int R4P_W  = 2 * R2_W;
    localparam int R4_W   = 33;
    localparam int R6P_W  = R4_W + R2_W;
    localparam int R6_W   = 37;
    localparam int KR1_W  = K_W + R2_W + 1;
    localparam int KR2_W  = K_W + R4_W + 1;
    localparam int KR3_W  = K_W + R6_W + 1;
    localparam int SS_W   = 44;
    localparam int S_W    = 33;
    localparam int XS_W   = XN_W + S_W;
    localparam int XD_W   = XS_W - 24;
    localparam int PF_W   = XD_W + FOC_W + 1;
    localparam int Q_W    = 34;

    localparam logic signed [DIFF_W-1:0] CX_D  = DIFF_W'(CX);
    localparam logic signed [DIFF_W-1:0] CY_D  = DIFF_W'(CY);
    localparam logic signed [P_W-1:0]    XN_HI = P_W'(64'sd1 <<< 28);
    localparam logic signed [P_W-1:0]    XN_LO = -XN_HI;
    localparam logic [SUM_W-25:0]        R2_LIM = (SUM_W-24)'(64'd1 << 28);
    localparam logic signed [SS_W-1:0]   ONE_S  = SS_W'(64'sd1 <<< 24);
    localparam logic signed [SS_W-1:0]   S_HI   = SS_W'(64'sd1 <<< 31);
    localparam logic signed [SS_W-1:0]   S_LO   = -S_HI;
    localparam logic signed [Q_W-1:0]    CX16   = Q_W'(CX * 16);
    localparam logic signed [Q_W-1:0]    CY16   = Q_W'(CY * 16);
    localparam logic signed [Q_W-1:0]    XLIM16 = Q_W'(IMG_WIDTH * 16);
    localparam logic signed [Q_W-1:0]    YLIM16 = Q_W'(IMG_HEIGHT * 16);
    localparam logic signed [Q_W-1:0]    NEG16  = -Q_W'(16);

    // ---------------- configuration registers ----------------
    logic signed [K_W-1:0] k1_reg, k2_reg, k3_reg;
    logic [FOC_W-1:0]      fx_reg, fy_reg;
    logic [INV_W-1:0]      ifx_reg, ify_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg  <= '0;
            k2_reg  <= '0;
            k3_reg  <= '0;
            fx_reg  <= FOCAL_RST;
            fy_reg  <= FOCAL_RST;
            ifx_reg <= INV_RST;
            ify_reg <= INV_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_K1:     k1_reg  <= cfg.data[K_W-1:0];
                REG_K2:     k2_reg  <= cfg.data[K_W-1:0];
                REG_K3:     k3_reg  <= cfg.data[K_W-1:0];
                REG_FX:     fx_reg  <= cfg.data[FOC_W-1:0];
                REG_FY:     fy_reg  <= cfg.data[FOC_W-1:0];
                REG_INV_FX: ifx_reg <= cfg.data[INV_W-1:0];
                REG_INV_FY: ify_reg <= cfg.data[INV_W-1:0];
                default:    ;
            endcase
        end
    end

    // ---------------- stage valid bits and advance chain ----------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] adv;

    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || map.ready;
        for (int i = NSTG - 2; i >= 0; i--)
            adv[i] = !vld_reg[i] || adv[i+1];
    end

    assign pix.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0])
                vld_reg[0] <= pix.valid;
            for (int i = 1; i < NSTG; i++)
                if (adv[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    // ---------------- stage 0: centre and normalize ----------------
    logic signed [DIFF_W-1:0] dx, dy;
    logic signed [P_W-1:0]    px0, py0;
    logic signed [XN_W-1:0]   xn_next, yn_next;
    logic signed [XN_W-1:0]   xn_reg [0:6];
    logic signed [XN_W-1:0]   yn_reg [0:6];

    always_comb
    begin
        dx  = $signed({{(DIFF_W-PIX_W){1'b0}}, pix.pixel_col}) - CX_D;
        dy  = $signed({{(DIFF_W-PIX_W){1'b0}}, pix.pixel_row}) - CY_D;
        px0 = dx * $signed({1'b0, ifx_reg});
        py0 = dy * $signed({1'b0, ify_reg});
        if (px0 > XN_HI)
            xn_next = XN_W'(XN_HI);
        else if (px0 < XN_LO)
            xn_next = XN_W'(XN_LO);
        else
            xn_next = XN_W'(px0);
        if (py0 > XN_HI)
            yn_next = XN_W'(XN_HI);
        else if (py0 < XN_LO)
            yn_next = XN_W'(XN_LO);
        else
            yn_next = XN_W'(py0);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            xn_reg[0] <= xn_next;
            yn_reg[0] <= yn_next;
        end
        for (int i = 1; i < 7; i++)
            if (adv[i])
            begin
                xn_reg[i] <= xn_reg[i-1];
                yn_reg[i] <= yn_reg[i-1];
            end
    end

    // ---------------- stage 1: squares ----------------
    logic signed [2*XN_W-1:0] sqx_full, sqy_full;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg;

    always_comb
    begin
        sqx_full = xn_reg[0] * xn_reg[0];
        sqy_full = yn_reg[0] * yn_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            sqx_reg <= sqx_full[SQ_W-1:0];
            sqy_reg <= sqy_full[SQ_W-1:0];
        end
    end

    // ---------------- stage 2: r2 ----------------
    logic [SUM_W-1:0]  sq_sum;
    logic [SUM_W-25:0] r2_sh;
    logic [R2_W-1:0]   r2_next;
    logic [R2_W-1:0]   r2_reg [2:3];

    always_comb
    begin
        sq_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        r2_sh  = sq_sum[SUM_W-1:24];
        r2_next = (r2_sh > R2_LIM) ? R2_W'(R2_LIM) : r2_sh[R2_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
            r2_reg[2] <= r2_next;
        if (adv[3])
            r2_reg[3] <= r2_reg[2];
    end

    // ---------------- stage 3: r2*r2, k1*r2 ----------------
    logic [R4P_W-1:0]        r4p_reg;
    logic signed [KR1_W-1:0] kr1_reg [3:5];

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            r4p_reg    <= r2_reg[2] * r2_reg[2];
            kr1_reg[3] <= k1_reg * $signed({1'b0, r2_reg[2]});
        end
        if (adv[4])
            kr1_reg[4] <= kr1_reg[3];
        if (adv[5])
            kr1_reg[5] <= kr1_reg[4];
    end

    // ---------------- stage 4: r4*r2, k2*r4 ----------------
    logic [R4_W-1:0]         r4;
    logic [R6P_W-1:0]        r6p_reg;
    logic signed [KR2_W-1:0] kr2_reg [4:5];

    assign r4 = r4p_reg[R4_W+23:24];

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            r6p_reg    <= r4 * r2_reg[3];
            kr2_reg[4] <= k2_reg * $signed({1'b0, r4});
        end
        if (adv[5])
            kr2_reg[5] <= kr2_reg[4];
    end

    // ---------------- stage 5: k3*r6 ----------------
    logic [R6_W-1:0]         r6;
    logic signed [KR3_W-1:0] kr3_reg;

    assign r6 = r6p_reg[R6_W+23:24];

    always_ff @(posedge clk)
    begin
        if (adv[5])
            kr3_reg <= k3_reg * $signed({1'b0, r6});
    end

    // ---------------- stage 6: scale factor ----------------
    logic signed [SS_W-1:0] s_sum;
    logic signed [S_W-1:0]  s_next, s_reg;

    always_comb
    begin
        s_sum = ONE_S + SS_W'(kr1_reg[5] >>> 20) + SS_W'(kr2_reg[5] >>> 20)
              + SS_W'(kr3_reg >>> 20);
        if (s_sum > S_HI)
            s_next = S_W'(S_HI);
        else if (s_sum < S_LO)
            s_next = S_W'(S_LO);
        else
            s_next = S_W'(s_sum);
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
            s_reg <= s_next;
    end

    // ---------------- stage 7: apply scale ----------------
    logic signed [XS_W-1:0] xs_reg, ys_reg;

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            xs_reg <= xn_reg[6] * s_reg;
            ys_reg <= yn_reg[6] * s_reg;
        end
    end

    // ---------------- stage 8: back to pixels ----------------
    logic signed [XD_W-1:0] xd, yd;
    logic signed [PF_W-1:0] pfx_reg, pfy_reg;

    always_comb
    begin
        xd = XD_W'(xs_reg >>> 24);
        yd = XD_W'(ys_reg >>> 24);
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            pfx_reg <= xd * $signed({1'b0, fx_reg});
            pfy_reg <= yd * $signed({1'b0, fy_reg});
        end
    end

    // ---------------- stage 9: recentre and clamp ----------------
    logic signed [Q_W-1:0]   qx, qy;
    logic signed [OUT_W-1:0] mx_next, my_next, mx_reg, my_reg;

    always_comb
    begin
        qx = Q_W'(pfx_reg >>> 28) + CX16;
        qy = Q_W'(pfy_reg >>> 28) + CY16;
        if (qx < 0)
            qx = NEG16;
        else if (qx > XLIM16)
            qx = XLIM16;
        if (qy < 0)
            qy = NEG16;
        else if (qy > YLIM16)
            qy = YLIM16;
        mx_next = qx[OUT_W-1:0];
        my_next = qy[OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[9])
        begin
            mx_reg <= mx_next;
            my_reg <= my_next;
        end
    end

    assign map.valid = vld_reg[NSTG-1];
    assign map.map_x = mx_reg;
    assign map.map_y = my_reg;

    // ---------------- checks ----------------
    `ASSERT_CLK(a_accept_fills, pix.valid && pix.ready |=> vld_reg[0], "accepted item lost")
    `ASSERT_CLK(a_out_holds, vld_reg[NSTG-1] && !map.ready |=> vld_reg[NSTG-1], "stalled result dropped")
    `ASSERT_CLK(a_stall_no_accept, vld_reg[0] && !adv[1] |-> !pix.ready, "input into blocked stage")
    `ASSERT_CLK(a_x_range, map.valid |-> map.map_x >= -16 && map.map_x <= XLIM16, "map_x out of range")
    `ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !map.valid, "result shown during reset")

endmodule

>>> bench/tb.sv
// Self-checking testbench for the radial distortion coordinate map.
`timescale 1ns / 1ps

module tb
    import rdm_pkg::*;
();

    localparam int     CYCLE_LIMIT = 300000;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam longint ONE_Q24 = longint'(1) << 24;
    localparam longint XN_MAX  = longint'(1) << 28;
    localparam longint R2_MAX  = longint'(1) << 28;
    localparam longint S_MAX   = longint'(1) << 31;

    typedef struct packed {
        logic [OUT_W-1:0] map_x;
        logic [OUT_W-1:0] map_y;
    } map_pos_t;

    logic clk = 1'b0;
    logic rst_n;

    rdm_pix_if pix_ch();
    rdm_map_if map_ch();
    rdm_cfg_if cfg_ch();

    radial_distortion_map i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_ch),
        .map   (map_ch),
        .cfg   (cfg_ch)
    );

    always #5 clk = ~clk;

    // Lens settings as the block should hold them
    logic signed [K_W-1:0] lens_k1     = '0;
    logic signed [K_W-1:0] lens_k2     = '0;
    logic signed [K_W-1:0] lens_k3     = '0;
    logic [FOC_W-1:0]      lens_fx     = FOCAL_RST;
    logic [FOC_W-1:0]      lens_fy     = FOCAL_RST;
    logic [INV_W-1:0]      lens_inv_fx = INV_RST;
    logic [INV_W-1:0]      lens_inv_fy = INV_RST;

    map_pos_t pending_maps[$];
    int       fail_count   = 0;
    int       cycle_count  = 0;
    int       burst_left   = 0;
    bit       gaps_enable  = 1'b0;
    bit       stall_enable = 1'b0;
    int       hold_request = 0;

    function automatic longint saturate(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Scale one normalized axis, back to Q.4 pixels, recenter and clamp.
    function automatic logic [OUT_W-1:0] pixel_axis(input longint xn, input longint s,
                                                    input longint focal, input longint centre,
                                                    input longint size);
        longint xd;
        longint q4;
        xd = (xn * s) >>> 24;
        q4 = ((xd * focal) >>> 28) + centre * 16;
        if (q4 < 0)
            q4 = -16;
        if (q4 > size * 16)
            q4 = size * 16;
        return OUT_W'(q4);
    endfunction

    function automatic map_pos_t distort_pixel(input logic [PIX_W-1:0] col,
                                               input logic [PIX_W-1:0] row);
        longint dx, dy, ix, iy, k1, k2, k3, fx, fy;
        longint xn, yn, r2, r4, r6, s;
        map_pos_t pos;
        dx = longint'(col);
        dy = longint'(row);
        ix = longint'(lens_inv_fx);
        iy = longint'(lens_inv_fy);
        k1 = longint'(lens_k1);
        k2 = longint'(lens_k2);
        k3 = longint'(lens_k3);
        fx = longint'(lens_fx);
        fy = longint'(lens_fy);
        xn = saturate((dx - CX) * ix, -XN_MAX, XN_MAX);
        yn = saturate((dy - CY) * iy, -XN_MAX, XN_MAX);
        r2 = (xn * xn + yn * yn) >>> 24;
        if (r2 > R2_MAX)
            r2 = R2_MAX;
        r4 = (r2 * r2) >>> 24;
        r6 = (r4 * r2) >>> 24;
        s = ONE_Q24 + ((k1 * r2) >>> 20) + ((k2 * r4) >>> 20) + ((k3 * r6) >>> 20);
        s = saturate(s, -S_MAX, S_MAX);
        pos.map_x = pixel_axis(xn, s, fx, longint'(CX), longint'(IMG_WIDTH));
        pos.map_y = pixel_axis(yn, s, fy, longint'(CY), longint'(IMG_HEIGHT));
        return pos;
    endfunction

    // Result checker
    always @(posedge clk) begin : check_results
        map_pos_t want;
        if (rst_n && map_ch.valid && map_ch.ready) begin
            if (pending_maps.size() == 0) begin
                $error("unexpected result: map_x %0d map_y %0d", map_ch.map_x, map_ch.map_y);
                fail_count++;
            end
            else begin
                want = pending_maps.pop_front();
                if (map_ch.map_x !== want.map_x) begin
                    $error("map_x: expected %0d, got %0d", $signed(want.map_x), map_ch.map_x);
                    fail_count++;
                end
                if (map_ch.map_y !== want.map_y) begin
                    $error("map_y: expected %0d, got %0d", $signed(want.map_y), map_ch.map_y);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random 16-bit ready mask while stalls are enabled, plus requested long hold-offs
    initial begin : result_sink
        int          mask_pos;
        int          hold_left;
        logic [15:0] ready_mask;
        mask_pos = 0;
        hold_left = 0;
        ready_mask = '1;
        map_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                map_ch.ready <= 1'b0;
            end
            else if (!stall_enable) begin
                map_ch.ready <= 1'b1;
            end
            else begin
                if (mask_pos == 0)
                    ready_mask = ($urandom_range(0, 3) == 0) ? 16'($urandom & $urandom)
                                                             : 16'($urandom | $urandom);
                map_ch.ready <= ready_mask[mask_pos];
                mask_pos = (mask_pos + 1) % 16;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_enable ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                pix_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.pixel_col <= col;
        pix_ch.pixel_row <= row;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        pending_maps.push_back(distort_pixel(col, row));
        burst_left--;
    endtask

    // Every item yields a result, so an empty queue means the pipeline is empty.
    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_maps.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_K1:     lens_k1     = data;
            REG_K2:     lens_k2     = data;
            REG_K3:     lens_k3     = data;
            REG_FX:     lens_fx     = data[FOC_W-1:0];
            REG_FY:     lens_fy     = data[FOC_W-1:0];
            REG_INV_FX: lens_inv_fx = data;
            REG_INV_FY: lens_inv_fy = data;
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_lens(input logic [CFG_DAT_W-1:0] k1, input logic [CFG_DAT_W-1:0] k2,
                                input logic [CFG_DAT_W-1:0] k3, input logic [CFG_DAT_W-1:0] fx,
                                input logic [CFG_DAT_W-1:0] fy, input logic [CFG_DAT_W-1:0] ifx,
                                input logic [CFG_DAT_W-1:0] ify);
        wait_idle();
        write_reg(REG_K1, k1);
        write_reg(REG_K2, k2);
        write_reg(REG_K3, k3);
        write_reg(REG_FX, fx);
        write_reg(REG_FY, fy);
        write_reg(REG_INV_FX, ifx);
        write_reg(REG_INV_FY, ify);
    endtask

    task automatic test_reset_defaults();
        send_pixel('0, '0);
        send_pixel(PIX_W'(IMG_WIDTH - 1), PIX_W'(IMG_HEIGHT - 1));
        send_pixel(PIX_W'(CX), PIX_W'(CY));
        send_pixel(PIX_W'(CX - 1), PIX_W'(CY - 1));
        send_pixel(10'h3FF, 10'h3FF);
        send_pixel(10'h155, 10'h2AA);
        send_pixel(10'h2AA, 10'h155);
        send_pixel('0, PIX_W'(IMG_HEIGHT - 1));
        send_pixel(PIX_W'(IMG_WIDTH - 1), '0);
    endtask

    task automatic test_special_cases();
        // strongest barrel term with saturated normalization: results fold across the centre
        program_lens(24'h800000, '0, '0, CFG_DAT_W'(FOCAL_RST), CFG_DAT_W'(FOCAL_RST),
                     24'hFFFFFF, 24'hFFFFFF);
        send_pixel(PIX_W'(IMG_WIDTH - 1), PIX_W'(IMG_HEIGHT - 1));
        send_pixel('0, '0);
        send_pixel(PIX_W'(CX), PIX_W'(CY));
        send_pixel(10'h3FF, '0);
        // all coefficients at maximum: far pixels saturate the scale and clamp to the image bounds
        program_lens(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, CFG_DAT_W'(FOCAL_RST),
                     CFG_DAT_W'(FOCAL_RST), 24'h010000, 24'h010000);
        send_pixel(PIX_W'(IMG_WIDTH - 1), PIX_W'(IMG_HEIGHT - 1));
        send_pixel('0, '0);
        send_pixel(PIX_W'(400), PIX_W'(300));
        // zero focal and zero reciprocal registers; unused index is ignored
        program_lens(24'h123456, 24'hFEDCBA, 24'h00FFFF, '0, '0, '0, '0);
        write_reg(REG_NONE, 24'hFFFFFF);
        send_pixel(PIX_W'(IMG_WIDTH - 1), PIX_W'(IMG_HEIGHT - 1));
        send_pixel(PIX_W'(5), PIX_W'(7));
        // widest focal length, upper data bits set on the focal writes
        program_lens('0, '0, '0, 24'hFFFFFF, 24'hFFFFFF, INV_RST, INV_RST);
        send_pixel(PIX_W'(IMG_WIDTH - 1), PIX_W'(IMG_HEIGHT - 1));
        send_pixel('0, '0);
    endtask

    // Output held off long enough that the pipeline fills and stalls its input.
    task automatic test_output_stall();
        program_lens(24'(-20000), 24'd3000, '0, 24'd150000, 24'd150000, 24'd28000, 24'd28000);
        stall_enable = 1'b0;
        gaps_enable = 1'b0;
        hold_request = 80;
        repeat (40)
            send_pixel(PIX_W'($urandom_range(0, IMG_WIDTH - 1)),
                       PIX_W'($urandom_range(0, IMG_HEIGHT - 1)));
    endtask

    task automatic test_random_mapping();
        int               f_pix;
        logic [FOC_W-1:0] fx, fy;
        logic [PIX_W-1:0] col, row;
        for (int p = 0; p < 7; p++) begin
            if (p == 0) begin
                program_lens(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h0FFFFF, 24'h0FFFFF,
                             24'hFFFFFF, 24'hFFFFFF);
            end
            else if (p == 1) begin
                program_lens(24'h800000, 24'h800000, 24'h800000, 24'd1, 24'd1, 24'd1, 24'd1);
            end
            else if ($urandom_range(0, 4) == 0) begin
                program_lens(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                             24'($urandom), 24'($urandom), 24'($urandom));
            end
            else begin
                f_pix = $urandom_range(200, 900);
                fx = FOC_W'(f_pix * 256 + $urandom_range(0, 255));
                fy = FOC_W'(f_pix * 256 + $urandom_range(0, 255));
                program_lens(24'($urandom_range(0, 1 << 20) - (1 << 19)),
                             24'($urandom_range(0, 1 << 19) - (1 << 18)),
                             24'($urandom_range(0, 1 << 17) - (1 << 16)),
                             {4'($urandom), fx}, {4'($urandom), fy},
                             24'((64'd1 << 32) / fx), 24'((64'd1 << 32) / fy));
            end
            // one phase runs without any idling on either side
            stall_enable = (p != 3);
            gaps_enable  = (p != 3);
            repeat (200) begin
                col = ($urandom_range(0, 4) == 0) ? PIX_W'($urandom)
                                                  : PIX_W'($urandom_range(0, IMG_WIDTH - 1));
                row = ($urandom_range(0, 4) == 0) ? PIX_W'($urandom)
                                                  : PIX_W'($urandom_range(0, IMG_HEIGHT - 1));
                send_pixel(col, row);
            end
        end
    endtask

    initial begin
        rst_n            <= 1'b0;
        pix_ch.valid     <= 1'b0;
        pix_ch.pixel_col <= '0;
        pix_ch.pixel_row <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= '0;
        cfg_ch.data      <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        stall_enable = 1'b1;
        gaps_enable  = 1'b1;
        test_reset_defaults();
        test_special_cases();
        test_output_stall();
        test_random_mapping();

        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
